/* sv/iprt_pkg.sv */
// Package for the IPv4 route prefix table: request and response types,
// command and status codes, and the layout of one stored route.
// No dependencies; every other file of the block imports it.
package iprt_pkg;

  // Default number of route slots.
  localparam int unsigned ROUTES_DEF = 64;

  // A mask with every bit set marks a host route.
  localparam logic [31:0] HOST_MASK = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ADD        = 2'd0,
    CMD_DELETE     = 2'd1,
    CMD_LOOKUP_ALL = 2'd2,
    CMD_LOOKUP_ONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] next_hop;
    logic [7:0]  iface_index;
    logic [31:0] route_metric;
    logic [7:0]  table_select;
  } in_req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] match_dest;
    logic [31:0] match_mask;
    logic [31:0] out_gateway;
    logic [7:0]  egress_iface;
    logic [31:0] out_metric;
    logic [7:0]  out_table;
    logic        is_gateway;
    logic        is_host;
    logic [5:0]  entry_slot;
    logic [6:0]  entry_count;
  } out_rsp_t;

  // One word of the route memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  iface;
    logic [31:0] metric;
    logic [7:0]  tbl;
  } entry_t;

  // Verdicts on the entry that has just come out of the memory.
  typedef struct packed {
    logic free;     // slot is unused, an add may take it
    logic key_hit;  // active entry with the requested destination and mask
    logic better;   // matching route that beats the best one so far
  } eval_t;

endpackage

/* sv/ip_route_prefix_table.sv */
// IPv4 route prefix table: a block of ROUTES route slots in one synchronous memory
// that adds, deletes and looks up routes with longest-prefix-match selection. Each
// request is handled by a scan that reads one slot per cycle from the route memory
// (one read and one write port, read data registered). An add stops at the first free
// slot and a delete at the first exact destination and mask match; lookups always cover
// every slot. The next request is taken in S_IDLE, which is entered once the finished
// response has moved from res_q into the output register.
// After reset the memory is swept once to clear the valid flag of every slot, and no
// request is taken during that pass. A finished response sits in an output register,
// so the next request is accepted while it waits.
// Depends on iprt_pkg and iprt_entry_eval.
module ip_route_prefix_table #(
  parameter int unsigned ROUTES = iprt_pkg::ROUTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iprt_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iprt_pkg::out_rsp_t out_rsp_o
);
  import iprt_pkg::*;

  localparam int unsigned IDX_W = $clog2(ROUTES);
  localparam int unsigned CNT_W = $clog2(ROUTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ROUTES);

  // Route memory: one word per slot, valid flag included.
  entry_t route_mem [ROUTES];

  state_e           state_q, state_d;
  in_req_t          req_q;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic             issue_q, issue_d;
  logic             eval_vld_q;
  logic [IDX_W-1:0] eval_idx_q;
  entry_t           rd_ent_q;
  logic             best_found_q;
  logic [IDX_W-1:0] best_idx_q;
  entry_t           best_ent_q;
  logic [CNT_W-1:0] count_q, count_d;
  out_rsp_t         res_q, res_d;
  logic             out_valid_q;
  out_rsp_t         out_q;

  logic             accept;
  logic             out_free;
  logic             mem_re;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  eval_t            ev;
  logic             is_lookup;
  logic             scan_eval;
  logic             hit_add;
  logic             hit_del;
  logic             upd_best;
  logic             last_eval;
  logic             scan_done;
  logic             fin_found;
  entry_t           fin_ent;
  logic [IDX_W-1:0] fin_idx;

  iprt_entry_eval u_eval (
    .req_i         (req_q),
    .entry_i       (rd_ent_q),
    .lead_mask_i   (best_ent_q.mask),
    .lead_metric_i (best_ent_q.metric),
    .eval_o        (ev)
  );

  // Verdicts on the word read in the previous cycle. The read issued in the cycle that
  // ends an add or delete scan lands in the result cycle and must not count.
  assign is_lookup = (req_q.command == CMD_LOOKUP_ALL) || (req_q.command == CMD_LOOKUP_ONE);
  assign scan_eval = eval_vld_q && (state_q == S_SCAN);
  assign hit_add   = scan_eval && (req_q.command == CMD_ADD) && ev.free;
  assign hit_del   = scan_eval && (req_q.command == CMD_DELETE) && ev.key_hit;
  assign upd_best  = scan_eval && is_lookup && ev.better;
  assign last_eval = eval_vld_q && (eval_idx_q == LAST_IDX);
  assign scan_done = hit_add || hit_del || last_eval;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (scan_idx_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controls of the memory ports and the scan counter.
  always_comb begin
    in_stall_o = 1'b1;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = scan_idx_q;
    mem_wd     = '0;
    scan_idx_d = scan_idx_q;
    issue_d    = issue_q;
    case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        scan_idx_d = scan_idx_q + 1'b1;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        scan_idx_d = '0;
        issue_d    = 1'b1;
      end
      S_SCAN: begin
        mem_re = issue_q;
        if (issue_q) begin
          if (scan_idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            scan_idx_d = scan_idx_q + 1'b1;
          end
        end
        mem_wa = eval_idx_q;
        if (hit_add) begin
          mem_we         = 1'b1;
          mem_wd.valid   = 1'b1;
          mem_wd.dest    = req_q.address;
          mem_wd.mask    = req_q.prefix_mask;
          mem_wd.gateway = req_q.next_hop;
          mem_wd.iface   = req_q.iface_index;
          mem_wd.metric  = req_q.route_metric;
          mem_wd.tbl     = req_q.table_select;
        end else if (hit_del) begin
          mem_we       = 1'b1;
          mem_wd       = rd_ent_q;
          mem_wd.valid = 1'b0;
        end
      end
      S_RESULT: begin
        issue_d = 1'b0;
      end
      default: begin
        issue_d = 1'b0;
      end
    endcase
  end

  // Response assembled in the cycle the scan finishes.
  always_comb begin
    count_d = count_q;
    if (hit_add) begin
      count_d = count_q + 1'b1;
    end else if (hit_del) begin
      count_d = count_q - 1'b1;
    end

    fin_found = best_found_q || upd_best;
    fin_ent   = upd_best ? rd_ent_q : best_ent_q;
    fin_idx   = upd_best ? eval_idx_q : best_idx_q;

    res_d             = '0;
    res_d.entry_count = 7'(count_d);
    case (req_q.command)
      CMD_ADD: begin
        if (hit_add) begin
          res_d.status     = STAT_OK;
          res_d.entry_slot = 6'(eval_idx_q);
        end else begin
          res_d.status = STAT_FULL;
        end
      end
      CMD_DELETE: begin
        if (hit_del) begin
          res_d.status     = STAT_OK;
          res_d.entry_slot = 6'(eval_idx_q);
        end else begin
          res_d.status = STAT_NONE;
        end
      end
      default: begin
        if (fin_found) begin
          res_d.status       = STAT_OK;
          res_d.match_dest   = fin_ent.dest;
          res_d.match_mask   = fin_ent.mask;
          res_d.out_gateway  = fin_ent.gateway;
          res_d.egress_iface = fin_ent.iface;
          res_d.out_metric   = fin_ent.metric;
          res_d.out_table    = fin_ent.tbl;
          res_d.is_gateway   = fin_ent.gateway != '0;
          res_d.is_host      = fin_ent.mask == HOST_MASK;
          res_d.entry_slot   = 6'(fin_idx);
        end else begin
          res_d.status = STAT_NONE;
        end
      end
    endcase
  end

  // Route memory: one write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      route_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_ent_q <= route_mem[scan_idx_q];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      scan_idx_q   <= '0;
      issue_q      <= 1'b0;
      eval_vld_q   <= 1'b0;
      best_found_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      issue_q    <= issue_d;
      eval_vld_q <= mem_re;
      count_q    <= count_d;
      if (accept) begin
        best_found_q <= 1'b0;
      end else if (upd_best) begin
        best_found_q <= 1'b1;
      end
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q             <= in_req_i;
      best_ent_q.mask   <= '0;
      best_ent_q.metric <= HOST_MASK;
    end
    if (mem_re) begin
      eval_idx_q <= scan_idx_q;
    end
    if (upd_best) begin
      best_ent_q <= rd_ent_q;
      best_idx_q <= eval_idx_q;
    end
    if (state_q == S_SCAN && scan_done) begin
      res_q <= res_d;
    end
    if (state_q == S_RESULT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The active count never passes the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL_CNT)
    else $error("active route count exceeds the table size");

  // Only adds and deletes modify the memory once the clearing pass is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != S_CLEAR) |->
      (req_q.command == CMD_ADD || req_q.command == CMD_DELETE))
    else $error("route memory written by a lookup");

  // A full response is only given when every slot is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && res_q.status == STAT_FULL) |-> count_q == FULL_CNT)
    else $error("table full reported with a free slot");

  // Read data is only judged for reads issued during a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_vld_q |-> $past(state_q) == S_SCAN)
    else $error("memory read outside a scan");

  // The scan ends by the time the last slot has been judged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && last_eval) |=> state_q == S_RESULT)
    else $error("scan ran past the last slot");

endmodule

/* sv/iprt_entry_eval.sv */
// Per-entry compare logic of the IPv4 route prefix table.
// Judges one route word against the current request and the best route.
// Depends on iprt_pkg.
module iprt_entry_eval (
  input  iprt_pkg::in_req_t req_i,
  input  iprt_pkg::entry_t  entry_i,
  input  logic [31:0]       lead_mask_i,
  input  logic [31:0]       lead_metric_i,
  output iprt_pkg::eval_t   eval_o
);
  import iprt_pkg::*;

  logic table_ok;
  logic prefix_ok;
  logic lpm_hit;

  always_comb begin
    table_ok  = (req_i.command != CMD_LOOKUP_ONE) || (entry_i.tbl == req_i.table_select);
    prefix_ok = (req_i.address & entry_i.mask) == entry_i.dest;
    lpm_hit   = entry_i.valid && table_ok && prefix_ok;

    eval_o.free    = !entry_i.valid;
    eval_o.key_hit = entry_i.valid && (entry_i.dest == req_i.address)
                     && (entry_i.mask == req_i.prefix_mask);
    // Longer (numerically larger) mask wins; on a tie, a strictly lower metric.
    eval_o.better  = lpm_hit && ((entry_i.mask > lead_mask_i)
                     || ((entry_i.mask == lead_mask_i) && (entry_i.metric < lead_metric_i)));
  end

endmodule
